// ===== src/ace_pkg.sv =====
// ace_pkg: shared types and constants of the accumulator execute block
// opcode values, decoded operation classes, queue word and status structs
// no dependencies
package ace_pkg;

   // instruction opcodes
   localparam logic [7:0] OPC_HALT         = 8'h00;
   localparam logic [7:0] OPC_LD_ROMADDR   = 8'h01;
   localparam logic [7:0] OPC_LD_DR_RADDR  = 8'h02;
   localparam logic [7:0] OPC_ST_DR        = 8'h03;
   localparam logic [7:0] OPC_LD_DR_MEM    = 8'h04;
   localparam logic [7:0] OPC_LD_ACC       = 8'h05;
   localparam logic [7:0] OPC_RD_ACC       = 8'h06;
   localparam logic [7:0] OPC_SET_DADDR    = 8'h07;
   localparam logic [7:0] OPC_LD_DR_DADDR  = 8'h08;
   localparam logic [7:0] OPC_ADD          = 8'h09;
   localparam logic [7:0] OPC_SUB          = 8'h0A;
   localparam logic [7:0] OPC_SWAP         = 8'h0B;
   localparam logic [7:0] OPC_ST_EXEC      = 8'h0C;
   localparam logic [7:0] OPC_JNZ          = 8'h0D;
   localparam logic [7:0] OPC_JMP          = 8'h0E;
   localparam logic [7:0] OPC_LD_DR_ROM    = 8'h0F;

   // item kinds
   localparam logic KIND_EXEC      = 1'b0;
   localparam logic KIND_ROM_WRITE = 1'b1;

   // value returned by a successful data address set
   localparam logic [15:0] DADDR_OK_VALUE = 16'h00FF;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [4:0] {
      OP_HALT         = 5'd0,
      OP_LD_ROMADDR   = 5'd1,
      OP_LD_DR_RADDR  = 5'd2,
      OP_ST_DR        = 5'd3,
      OP_LD_DR_MEM    = 5'd4,
      OP_LD_ACC       = 5'd5,
      OP_RD_ACC       = 5'd6,
      OP_SET_DADDR    = 5'd7,
      OP_LD_DR_DADDR  = 5'd8,
      OP_ADD          = 5'd9,
      OP_SUB          = 5'd10,
      OP_SWAP         = 5'd11,
      OP_ST_EXEC      = 5'd12,
      OP_JNZ          = 5'd13,
      OP_JMP          = 5'd14,
      OP_LD_DR_ROM    = 5'd15,
      OP_UNKNOWN      = 5'd16,
      OP_ROM_WRITE    = 5'd17
   } op_type;

   // decoded word passed from front to back
   typedef struct packed {
      op_type      op;
      logic [7:0]  opcode;
      logic [15:0] argument;
      logic [15:0] fill_address;
   } item_type;

   // back status seen by the front
   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

// ===== src/ace_ram.sv =====
// ace_ram: generic single write port, single read port ram with registered read
// no dependencies
module ace_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ace_front.sv =====
// ace_front: accepts request words and decodes them into operation classes
// depends on ace_pkg
module ace_front
   import ace_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_item_kind,
   input  logic [7:0]  req_opcode,
   input  logic [15:0] req_argument,
   input  logic [15:0] req_rom_fill_address,
   input  status_type  status,
   output logic        push_valid,
   input  logic        push_ready,
   output item_type    push_item
);

   op_type op;

   always_comb begin
      if (req_item_kind == KIND_ROM_WRITE) begin
         op = OP_ROM_WRITE;
      end else begin
         unique case (req_opcode)
            OPC_HALT:        op = OP_HALT;
            OPC_LD_ROMADDR:  op = OP_LD_ROMADDR;
            OPC_LD_DR_RADDR: op = OP_LD_DR_RADDR;
            OPC_ST_DR:       op = OP_ST_DR;
            OPC_LD_DR_MEM:   op = OP_LD_DR_MEM;
            OPC_LD_ACC:      op = OP_LD_ACC;
            OPC_RD_ACC:      op = OP_RD_ACC;
            OPC_SET_DADDR:   op = OP_SET_DADDR;
            OPC_LD_DR_DADDR: op = OP_LD_DR_DADDR;
            OPC_ADD:         op = OP_ADD;
            OPC_SUB:         op = OP_SUB;
            OPC_SWAP:        op = OP_SWAP;
            OPC_ST_EXEC:     op = OP_ST_EXEC;
            OPC_JNZ:         op = OP_JNZ;
            OPC_JMP:         op = OP_JMP;
            OPC_LD_DR_ROM:   op = OP_LD_DR_ROM;
            default:         op = OP_UNKNOWN;
         endcase
      end
   end

   // hold off while the back sweeps its memories after reset
   assign req_ready  = push_ready && !status.clearing;
   assign push_valid = req_valid && !status.clearing;

   assign push_item.op           = op;
   assign push_item.opcode       = req_opcode;
   assign push_item.argument     = req_argument;
   assign push_item.fill_address = req_rom_fill_address;

endmodule

// ===== src/ace_queue.sv =====
// ace_queue: short fifo of decoded words between front and back
// depends on ace_pkg
module ace_queue
   import ace_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/ace_back.sv =====
// ace_back: machine registers, data and rom stores, instruction execution
// and the response register; depends on ace_pkg and ace_ram
module ace_back
   import ace_pkg::*;
#(
   parameter int DATA_DEPTH = 8192,
   parameter int ROM_DEPTH  = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  item_type    pop_item,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_value,
   output logic        rsp_halt,
   output logic [15:0] rsp_next_exec_address
);

   localparam int DA_W      = $clog2(DATA_DEPTH);
   localparam int RA_W      = $clog2(ROM_DEPTH);
   localparam int MAX_DEPTH = (DATA_DEPTH > ROM_DEPTH) ? DATA_DEPTH : ROM_DEPTH;
   localparam int CLR_W     = $clog2(MAX_DEPTH);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_ISSUE = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CLR_W-1:0]   clr_cnt_ff, clr_cnt_in;

   logic [15:0]        acc_ff, acc_in;
   logic [15:0]        dr_ff, dr_in;
   logic [DA_W-1:0]    daddr_ff, daddr_in;
   logic [15:0]        raddr_ff, raddr_in;
   logic [15:0]        exec_ff, exec_in;

   item_type           cur_ff;
   logic               rom_ok_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_value_ff, rsp_value_in;
   logic               rsp_halt_ff, rsp_halt_in;
   logic [15:0]        rsp_exec_ff;

   logic               issue, retire;
   logic [15:0]        data_rd, rom_rd;
   logic               data_we, rom_we;
   logic [DA_W-1:0]    data_wa;
   logic [RA_W-1:0]    rom_wa;
   logic [15:0]        data_wd, rom_wd;
   logic               clr_data, clr_rom;

   assign issue     = (state_ff == ST_ISSUE) && pop_valid;
   assign pop_ready = (state_ff == ST_ISSUE);
   assign retire    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign status.clearing = (state_ff == ST_CLEAR);

   assign clr_data = ({1'b0, clr_cnt_ff} < (CLR_W + 1)'(DATA_DEPTH));
   assign clr_rom  = ({1'b0, clr_cnt_ff} < (CLR_W + 1)'(ROM_DEPTH));

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_W'(MAX_DEPTH - 1)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (issue) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (retire) begin
               state_in = ST_ISSUE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // execute
   always_comb begin
      acc_in       = acc_ff;
      dr_in        = dr_ff;
      daddr_in     = daddr_ff;
      raddr_in     = raddr_ff;
      exec_in      = exec_ff;
      rsp_value_in = '0;
      rsp_halt_in  = 1'b0;
      unique case (cur_ff.op)
         OP_HALT:        rsp_halt_in = 1'b1;
         OP_LD_ROMADDR:  raddr_in = dr_ff;
         OP_LD_DR_RADDR: dr_in = raddr_ff;
         OP_ST_DR:       ;
         OP_LD_DR_MEM:   dr_in = data_rd;
         OP_LD_ACC: begin
            acc_in       = cur_ff.argument;
            rsp_value_in = cur_ff.argument;
         end
         OP_RD_ACC:      rsp_value_in = acc_ff;
         OP_SET_DADDR: begin
            if ({1'b0, dr_ff} < 17'(DATA_DEPTH)) begin
               daddr_in     = dr_ff[DA_W-1:0];
               rsp_value_in = DADDR_OK_VALUE;
            end
         end
         OP_LD_DR_DADDR: begin
            dr_in        = 16'(daddr_ff);
            rsp_value_in = 16'(daddr_ff);
         end
         OP_ADD: begin
            acc_in       = acc_ff + cur_ff.argument;
            rsp_value_in = acc_ff + cur_ff.argument;
         end
         OP_SUB: begin
            acc_in       = acc_ff - cur_ff.argument;
            rsp_value_in = acc_ff - cur_ff.argument;
         end
         OP_SWAP: begin
            acc_in = dr_ff;
            dr_in  = acc_ff;
         end
         OP_ST_EXEC:     ;
         OP_JNZ: begin
            if (acc_ff != '0) begin
               exec_in = data_rd;
            end
         end
         OP_JMP:         exec_in = cur_ff.argument;
         OP_LD_DR_ROM:   dr_in = rom_ok_ff ? rom_rd : '0;
         OP_UNKNOWN:     rsp_value_in = 16'(cur_ff.opcode);
         OP_ROM_WRITE:   ;
         default:        ;
      endcase
   end

   // memory write ports: clearing sweep or retiring store
   always_comb begin
      data_we = 1'b0;
      data_wa = daddr_ff;
      data_wd = '0;
      rom_we  = 1'b0;
      rom_wa  = cur_ff.fill_address[RA_W-1:0];
      rom_wd  = cur_ff.argument;
      if (state_ff == ST_CLEAR) begin
         data_we = clr_data;
         data_wa = clr_cnt_ff[DA_W-1:0];
         rom_we  = clr_rom;
         rom_wa  = clr_cnt_ff[RA_W-1:0];
         rom_wd  = '0;
      end else if (retire) begin
         data_we = (cur_ff.op == OP_ST_DR) || (cur_ff.op == OP_ST_EXEC);
         data_wd = (cur_ff.op == OP_ST_DR) ? dr_ff : exec_ff;
         rom_we  = (cur_ff.op == OP_ROM_WRITE) &&
                   ({1'b0, cur_ff.fill_address} < 17'(ROM_DEPTH));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         acc_ff       <= '0;
         dr_ff        <= '0;
         daddr_ff     <= '0;
         raddr_ff     <= '0;
         exec_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (retire) begin
            acc_ff   <= acc_in;
            dr_ff    <= dr_in;
            daddr_ff <= daddr_in;
            raddr_ff <= raddr_in;
            exec_ff  <= exec_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cur_ff    <= pop_item;
         rom_ok_ff <= ({1'b0, raddr_ff} < 17'(ROM_DEPTH));
      end
      if (retire) begin
         rsp_value_ff <= rsp_value_in;
         rsp_halt_ff  <= rsp_halt_in;
         rsp_exec_ff  <= exec_in;
      end
   end

   ace_ram #(
      .WIDTH (16),
      .DEPTH (DATA_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wa),
      .wr_data (data_wd),
      .rd_en   (issue),
      .rd_addr (daddr_ff),
      .rd_data (data_rd)
   );

   ace_ram #(
      .WIDTH (16),
      .DEPTH (ROM_DEPTH)
   ) u_rom_ram (
      .clock   (clock),
      .wr_en   (rom_we),
      .wr_addr (rom_wa),
      .wr_data (rom_wd),
      .rd_en   (issue),
      .rd_addr (raddr_ff[RA_W-1:0]),
      .rd_data (rom_rd)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_value      = rsp_value_ff;
   assign rsp_halt              = rsp_halt_ff;
   assign rsp_next_exec_address = rsp_exec_ff;

endmodule

// ===== src/accumulator_cpu_execute.sv =====
// accumulator_cpu_execute: top level of the accumulator machine execute block
// depends on ace_pkg, ace_front, ace_queue, ace_back (and ace_ram below it)
//
// each request word carries one instruction (or one rom store write) and
// yields exactly one response word with the returned value, the halt flag
// and the execution address after the instruction. the front decodes words
// into a two-entry queue so that requests keep flowing while the back is
// busy or the response side stalls. each word passes through the back's
// issue state, which reads the data store and the rom store at the current
// addresses (both rams have registered read ports), and its execute state,
// which executes, writes back and waits while the response register is
// full; no new word is taken until the current one retires. after reset
// the back sweeps both stores to zero, one entry a cycle, over every entry
// of the larger store; req_ready stays low during that sweep.
module accumulator_cpu_execute
   import ace_pkg::*;
#(
   parameter int DATA_DEPTH = 8192,
   parameter int ROM_DEPTH  = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_item_kind,
   input  logic [7:0]  req_opcode,
   input  logic [15:0] req_argument,
   input  logic [15:0] req_rom_fill_address,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_value,
   output logic        rsp_halt,
   output logic [15:0] rsp_next_exec_address
);

   status_type status;
   logic       push_valid, push_ready;
   item_type   push_item;
   logic       pop_valid, pop_ready;
   item_type   pop_item;

   // decode into operation classes
   ace_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_item_kind        (req_item_kind),
      .req_opcode           (req_opcode),
      .req_argument         (req_argument),
      .req_rom_fill_address (req_rom_fill_address),
      .status               (status),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_item            (push_item)
   );

   // decouples decode from execute
   ace_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // machine state, stores and response register
   ace_back #(
      .DATA_DEPTH (DATA_DEPTH),
      .ROM_DEPTH  (ROM_DEPTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .pop_valid             (pop_valid),
      .pop_ready             (pop_ready),
      .pop_item              (pop_item),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_value      (rsp_result_value),
      .rsp_halt              (rsp_halt),
      .rsp_next_exec_address (rsp_next_exec_address)
   );

endmodule
